/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

/* sv/bfh_pkg.sv */
package bfh_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int FREQ_BITS   = 32;
    localparam int ADDR_BITS   = 8;
    localparam int TABLE_DEPTH = 1 << ADDR_BITS;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                 opcode;
        logic [ADDR_BITS-1:0] byte_value;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] key_byte;
        logic [FREQ_BITS-1:0] frequency;
    } res_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        logic [COUNT_BITS-1:0] data;
    } tbl_wr_t;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // clamp a counter value to the reported field width
    function automatic logic [FREQ_BITS-1:0] sat_freq(input logic [COUNT_BITS-1:0] c);
        logic [63:0] c64;
        c64 = 64'(c);
        if (c64 > 64'h0000_0000_FFFF_FFFF)
            return '1;
        return c64[FREQ_BITS-1:0];
    endfunction

endpackage

/* sv/bfh_count_ram.sv */
module bfh_count_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/bfh_table.sv */
module bfh_table import bfh_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output logic [COUNT_BITS-1:0] rd_data,
    input  tbl_wr_t               wr
);

    // per-entry valid bits; an entry never written since reset reads as zero
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic                   vld_rd_reg;
    logic [COUNT_BITS-1:0]  ram_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_rd_reg <= vld_reg[rd_addr];
            end
        end
    end

    bfh_count_ram #(
        .DATA_W (COUNT_BITS),
        .ADDR_W (ADDR_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data)
    );

    assign rd_data = vld_rd_reg ? ram_q : '0;

endmodule

/* sv/byte_frequency_histogram.sv */
// Throughput: one command beat per cycle, repeated bytes included (write-back forwarding),
// unless a read beat in stage 1 waits on res_stall. A read beat passes through the stage 1
// registers and then the output register that drives res. Count beats give no result;
// their table update is written from stage 1. Reset: async active low; 256 valid flops
// zero the whole table at once, no sweep. skip_whitespace resets to 1.
`include "assert_macros.svh"

module byte_frequency_histogram import bfh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    // config register
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    // command channel
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    // result channel
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // ------------------------------------------------------------------
    // Config
    // ------------------------------------------------------------------
    logic skip_ws_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_ws_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            skip_ws_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept beat, issue table read.
    // Stage 1: table data is back; modify and write back.
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [ADDR_BITS-1:0]  s1_byte_reg;
    logic                  fwd_hit_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    res_t                  res_reg;

    logic                  acc;
    logic                  s1_res;
    logic                  s1_go;
    logic                  s1_wr;
    logic                  out_free;
    logic [COUNT_BITS-1:0] tbl_q;
    logic [COUNT_BITS-1:0] s1_cur;
    logic [COUNT_BITS-1:0] s1_new;
    logic                  fwd_hit_next;
    tbl_wr_t               tbl_wr;

    assign out_free = !out_valid_reg || !res_stall;
    assign s1_res   = s1_valid_reg && (s1_op_reg == OP_READ);
    // only a read beat needs the output register; counts always retire
    assign s1_go    = s1_valid_reg && (!s1_res || out_free);
    assign cmd_stall = s1_valid_reg && !s1_go;
    assign acc      = cmd_valid && !cmd_stall;

    // skipped whitespace leaves the table untouched
    assign s1_wr = s1_go &&
                   !((s1_op_reg == OP_COUNT) && skip_ws_reg && is_blank(s1_byte_reg));

    // RAM reads before the write at the same edge lands, so a back-to-back
    // beat on the same byte takes the value being written instead
    assign fwd_hit_next = s1_wr && (s1_byte_reg == cmd.byte_value);
    assign s1_cur = fwd_hit_reg ? fwd_data_reg : tbl_q;

    always_comb
    begin
        if (s1_op_reg == OP_READ)
        begin
            s1_new = '0;
        end
        else if (s1_cur == CNT_MAX)
        begin
            s1_new = s1_cur;
        end
        else
        begin
            s1_new = s1_cur + COUNT_BITS'(1);
        end
    end

    assign tbl_wr.en   = s1_wr;
    assign tbl_wr.addr = s1_byte_reg;
    assign tbl_wr.data = s1_new;

    bfh_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (acc),
        .rd_addr (cmd.byte_value),
        .rd_data (tbl_q),
        .wr      (tbl_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (acc)
        begin
            s1_valid_reg <= 1'b1;
            fwd_hit_reg  <= fwd_hit_next;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_op_reg    <= cmd.opcode;
            s1_byte_reg  <= cmd.byte_value;
            fwd_data_reg <= s1_new;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_res)
        begin
            res_reg.key_byte  <= s1_byte_reg;
            res_reg.frequency <= sat_freq(s1_cur);
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_no_stall_when_empty, clk,
        !s1_valid_reg |-> !cmd_stall,
        "command stalled with stage 1 empty")

    `ASSERT_CLK(a_read_reaches_output, clk, rst_n,
        (s1_go && s1_res) |=> (out_valid_reg && res_reg.key_byte == $past(s1_byte_reg)),
        "retired read beat did not land in the output register")

    `ASSERT_CLK(a_read_clear_forwarded, clk, rst_n,
        (s1_go && s1_res && acc && cmd.byte_value == s1_byte_reg) |=> (s1_cur == '0),
        "cleared entry not forwarded to following beat")

endmodule
